// ===== rtl/twq_pkg.sv =====
// ----------------------------------------------------------------------------
// twq_pkg
// shared types and the key compare for the three-way quicksort block
// ----------------------------------------------------------------------------
package twq_pkg;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_LOAD  = 11'b00000000001,
		ST_POP   = 11'b00000000010,
		ST_PIV   = 11'b00000000100,
		ST_CNT   = 11'b00000001000,
		ST_CNTE  = 11'b00000010000,
		ST_DIST  = 11'b00000100000,
		ST_DISTE = 11'b00001000000,
		ST_COPY  = 11'b00010000000,
		ST_COPYE = 11'b00100000000,
		ST_PUSH  = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	// key compare: -1 less, 0 equal, 1 greater as two flags
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

	function automatic cmp_t cmp_key(input logic [31:0] a, input logic [31:0] p);
		cmp_t c;
		c.lt = $signed(a) < $signed(p);
		c.eq = a == p;
		return c;
	endfunction

endpackage

// ===== rtl/twq_ram.sv =====
// ----------------------------------------------------------------------------
// twq_ram
// generic single-port-write, one-read ram with registered read
// ----------------------------------------------------------------------------
module twq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/three_way_quicksort.sv =====
// ----------------------------------------------------------------------------
// three_way_quicksort
// collects signed values, sorts them by three-way quicksort, streams them out
// ----------------------------------------------------------------------------
// channel   dir  tdata                         tuser     tlast
// s_axis    in   [31:0] value                  -         last_in
// m_axis    out  [31:0] sorted_value           overflow  last_out
//
// loading takes one item per cycle, one store write each while the store has room
// sorting a range is paced by the single read port of the element store;
// output stalls while m_axis_tready is low
// s_axis_tready is low from the last item until the last result is taken
// reset clears the sequencer, counts and stack pointer; memories are not cleared
module three_way_quicksort #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] overflow
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	twq_pkg::state_t state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, i_q, plt_q, peq_q, pgt_q, nlt_q, neq_q;
	logic [CW-1:0] sp_q;
	logic [31:0] pivot_q;
	logic ovf_q, last_full_q;

	// element store
	logic es_we;
	logic [AW-1:0] es_wa, es_ra;
	logic [31:0] es_wd, es_rd;
	// scratch
	logic sc_we;
	logic [AW-1:0] sc_wa, sc_ra;
	logic [31:0] sc_wd, sc_rd;
	// range stack
	logic st_we;
	logic [AW-1:0] st_wa, st_ra;
	logic [2*CW-1:0] st_wd, st_rd;

	twq_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_store (
		.clk(clk), .we(es_we), .waddr(es_wa), .wdata(es_wd), .raddr(es_ra), .rdata(es_rd));
	twq_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_scratch (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));
	twq_ram #(.WIDTH(2*CW), .DEPTH(MAX_ITEMS)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

	twq_pkg::cmp_t c;
	assign c = twq_pkg::cmp_key(es_rd, pivot_q);

	// output register
	logic ov_q;
	logic [31:0] od_q;
	logic ol_q, ou_q;
	logic out_ld;
	logic rd_issue;
	logic pend_q;   // read of next output element in flight
	logic [CW-1:0] oi_q;
	logic push_a_q;

	assign s_axis_tready = state_q == twq_pkg::ST_LOAD;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tlast  = ol_q;
	assign m_axis_tuser  = ou_q;

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign out_ld = pend_q && (!ov_q || m_axis_tready);
	assign rd_issue = (state_q == twq_pkg::ST_OUT) && (!pend_q || out_ld) && (oi_q != count_q);

	always_comb begin
		es_we = 1'b0;
		es_wa = count_q[AW-1:0];
		es_wd = s_axis_tdata;
		es_ra = i_q[AW-1:0];
		sc_we = 1'b0;
		sc_wa = plt_q[AW-1:0];
		sc_wd = es_rd;
		sc_ra = i_q[AW-1:0];
		st_we = 1'b0;
		st_wa = sp_q[AW-1:0];
		st_wd = {lo_q, hi_q};
		st_ra = AW'(sp_q - 1'b1);
		unique case (state_q)
			twq_pkg::ST_LOAD: begin
				es_we = acc && (count_q < CW'(MAX_ITEMS));
				st_we = acc && s_axis_tlast;
				st_wa = '0;
				st_wd = {{CW{1'b0}}, (count_q < CW'(MAX_ITEMS)) ? CW'(count_q + 1'b1)
					: count_q};
			end
			// pivot address comes straight from the popped range
			twq_pkg::ST_PIV: es_ra = st_rd[CW+AW-1:CW];
			twq_pkg::ST_DIST, twq_pkg::ST_DISTE: begin
				if (state_q == twq_pkg::ST_DIST) es_ra = lo_q[AW-1:0];
				sc_we = state_q == twq_pkg::ST_DISTE;
				sc_wa = c.lt ? plt_q[AW-1:0] : (c.eq ? peq_q[AW-1:0] : pgt_q[AW-1:0]);
			end
			twq_pkg::ST_COPYE: begin
				es_we = 1'b1;
				es_wa = AW'(i_q - 1'b1);
				es_wd = sc_rd;
			end
			twq_pkg::ST_PUSH: begin
				st_we = push_a_q ? (nlt_q >= CW'(2)) : (hi_q - pgt_q >= CW'(2));
				st_wd = push_a_q ? {lo_q, CW'(lo_q + nlt_q)} : {pgt_q, hi_q};
				st_we = st_we && (sp_q < CW'(MAX_ITEMS));
			end
			// hold the pending element's address while the output stalls
			twq_pkg::ST_OUT: es_ra = (pend_q && !out_ld) ? AW'(oi_q - 1'b1) : oi_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twq_pkg::ST_LOAD;
			count_q <= '0;
			sp_q <= '0;
			ovf_q <= 1'b0;
			ov_q <= 1'b0;
			pend_q <= 1'b0;
			oi_q <= '0;
			i_q <= '0;
			push_a_q <= 1'b0;
			last_full_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			plt_q <= '0;
			peq_q <= '0;
			pgt_q <= '0;
			nlt_q <= '0;
			neq_q <= '0;
			pivot_q <= '0;
		end else begin
			if (out_ld) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
			if (rd_issue) pend_q <= 1'b1;
			else if (out_ld) pend_q <= 1'b0;
			unique case (state_q)
				twq_pkg::ST_LOAD: if (acc) begin
					if (count_q < CW'(MAX_ITEMS)) count_q <= CW'(count_q + 1'b1);
					else ovf_q <= 1'b1;
					if (s_axis_tlast) begin
						last_full_q <= 1'b0;
						// push only a range of two or more
						if ((count_q < CW'(MAX_ITEMS) ? CW'(count_q + 1'b1) : count_q)
							>= CW'(2)) sp_q <= CW'(1);
						else sp_q <= '0;
						state_q <= twq_pkg::ST_POP;
					end
				end
				twq_pkg::ST_POP: begin
					if (sp_q == '0) begin
						oi_q <= '0;
						state_q <= twq_pkg::ST_OUT;
					end else begin
						state_q <= twq_pkg::ST_PIV;
						sp_q <= CW'(sp_q - 1'b1);
					end
				end
				twq_pkg::ST_PIV: begin
					{lo_q, hi_q} <= st_rd;
					state_q <= twq_pkg::ST_CNT;
				end
				twq_pkg::ST_CNT: begin
					// pivot read is out now, start scanning
					pivot_q <= es_rd;
					i_q <= lo_q;
					nlt_q <= '0;
					neq_q <= '0;
					state_q <= twq_pkg::ST_CNTE;
				end
				twq_pkg::ST_CNTE: begin
					if (i_q != lo_q || last_full_q) begin
						if (c.lt) nlt_q <= CW'(nlt_q + 1'b1);
						else if (c.eq) neq_q <= CW'(neq_q + 1'b1);
					end
					if (i_q == hi_q) begin
						state_q <= twq_pkg::ST_DIST;
						last_full_q <= 1'b0;
					end else begin
						i_q <= CW'(i_q + 1'b1);
						last_full_q <= 1'b1;
					end
				end
				twq_pkg::ST_DIST: begin
					plt_q <= lo_q;
					peq_q <= CW'(lo_q + nlt_q);
					pgt_q <= CW'(lo_q + nlt_q + neq_q);
					i_q <= CW'(lo_q + 1'b1);
					state_q <= twq_pkg::ST_DISTE;
				end
				twq_pkg::ST_DISTE: begin
					if (c.lt) plt_q <= CW'(plt_q + 1'b1);
					else if (c.eq) peq_q <= CW'(peq_q + 1'b1);
					else pgt_q <= CW'(pgt_q + 1'b1);
					if (i_q == hi_q) begin
						i_q <= lo_q;
						state_q <= twq_pkg::ST_COPY;
					end else begin
						i_q <= CW'(i_q + 1'b1);
					end
				end
				twq_pkg::ST_COPY: begin
					i_q <= CW'(lo_q + 1'b1);
					state_q <= twq_pkg::ST_COPYE;
				end
				twq_pkg::ST_COPYE: begin
					if (i_q == hi_q) begin
						pgt_q <= CW'(lo_q + nlt_q + neq_q);
						push_a_q <= 1'b1;
						state_q <= twq_pkg::ST_PUSH;
					end else begin
						i_q <= CW'(i_q + 1'b1);
					end
				end
				twq_pkg::ST_PUSH: begin
					if (st_we) sp_q <= CW'(sp_q + 1'b1);
					push_a_q <= 1'b0;
					if (!push_a_q) state_q <= twq_pkg::ST_POP;
				end
				twq_pkg::ST_OUT: begin
					if (!pend_q || out_ld) begin
						if (oi_q == count_q) begin
							if (!pend_q && !ov_q) begin
								count_q <= '0;
								ovf_q <= 1'b0;
								state_q <= twq_pkg::ST_LOAD;
							end
						end else begin
							oi_q <= CW'(oi_q + 1'b1);
						end
					end
				end
				default: state_q <= twq_pkg::ST_LOAD;
			endcase
		end
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (out_ld) begin
			od_q <= es_rd;
			ol_q <= oi_q == count_q;
			ou_q <= ovf_q;
		end
	end

`ifndef SYNTH
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != twq_pkg::ST_LOAD |-> !s_axis_tready)
		else $error("input accepted while sorting");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_ITEMS))
		else $error("range stack overrun");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("element count overrun");
	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> state_q == twq_pkg::ST_OUT)
		else $error("result loaded outside output phase");
`endif
endmodule
